FILE: hdl/srsw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srsw_pkg;

	// Opcodes of an input item
	localparam logic [1:0] OP_SEND    = 2'd0;
	localparam logic [1:0] OP_ACK     = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;

	// Result status codes
	localparam logic [2:0] RS_SENT      = 3'd0;
	localparam logic [2:0] RS_FULL      = 3'd1;
	localparam logic [2:0] RS_ACK_TAKEN = 3'd2;
	localparam logic [2:0] RS_CORRUPT   = 3'd3;
	localparam logic [2:0] RS_OUTSIDE   = 3'd4;
	localparam logic [2:0] RS_RESENT    = 3'd5;
	localparam logic [2:0] RS_IGNORED   = 3'd6;

	// Window size after reset
	localparam logic [2:0] WIN_RESET = 3'd4;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [2:0]  seq_in;
		logic        checksum_ok;
		logic [63:0] payload;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        tx_valid;
		logic [2:0]  tx_seq;
		logic [63:0] tx_payload;
		logic        timer_start;
		logic        timer_stop;
		logic [2:0]  timer_seq;
		logic [2:0]  window_base;
		logic [2:0]  next_seq_out;
	} res_item_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic       load;
		logic       send;
		logic       mark;
		logic       step;
		logic       rd;
		logic       emit;
		logic [2:0] emit_code;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       full;
		logic       ck_ok;
		logic       in_flight;
		logic       acked_s;
		logic       slide_more;
		logic       out_busy;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: hdl/srsw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module srsw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/srsw_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module srsw_dp
	import srsw_pkg::*;
#(
	parameter int SEQ_BITS     = 3,
	parameter int PAYLOAD_BITS = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic [2:0] cfg_wdata,
	input  wire in_item_t  in_item,
	input  wire dp_cmd_t   cmd,
	output dp_stat_t       stat,
	input  wire logic      out_ready,
	output logic           out_valid,
	output res_item_t      out_item
);

	localparam int SEQ_RANGE = 1 << SEQ_BITS;
	localparam int WIN_W     = (SEQ_BITS > 3) ? SEQ_BITS : 3;
	localparam logic [WIN_W-1:0] SEQ_MAX = WIN_W'(SEQ_RANGE - 1);

	logic [2:0]              window_q;
	logic [SEQ_BITS-1:0]     base_q;
	logic [SEQ_BITS-1:0]     next_q;
	logic [SEQ_RANGE-1:0]    acked_q;
	logic                    stop_q;
	in_item_t                item_q;
	logic                    out_valid_q;
	res_item_t               out_q;

	logic [WIN_W-1:0]        eff_win;
	logic [SEQ_BITS-1:0]     s;
	logic [SEQ_BITS-1:0]     outstanding;
	logic [SEQ_BITS-1:0]     off;
	logic [SEQ_BITS-1:0]     next_inc;
	logic [SEQ_BITS-1:0]     base_inc;
	logic [PAYLOAD_BITS-1:0] pay_keep;
	logic [PAYLOAD_BITS-1:0] rd_data;
	res_item_t               res;

	// Effective window: zero acts as one, capped at the sequence range less one
	always_comb begin
		eff_win = WIN_W'(window_q);
		if (window_q == 3'd0) begin
			eff_win = WIN_W'(1);
		end
		if (eff_win > SEQ_MAX) begin
			eff_win = SEQ_MAX;
		end
	end

	assign s           = SEQ_BITS'(item_q.seq_in);
	assign outstanding = next_q - base_q;
	assign off         = s - base_q;
	assign next_inc    = next_q + SEQ_BITS'(1);
	assign base_inc    = base_q + SEQ_BITS'(1);
	assign pay_keep    = item_q.payload[PAYLOAD_BITS-1:0];

	// Status toward the controller
	always_comb begin
		stat.op         = item_q.opcode;
		stat.full       = WIN_W'(outstanding) >= eff_win;
		stat.ck_ok      = item_q.checksum_ok;
		stat.in_flight  = (WIN_W'(off) < eff_win) && (off < outstanding);
		stat.acked_s    = acked_q[s];
		stat.slide_more = (base_q != next_q) && acked_q[base_q];
		stat.out_busy   = out_valid_q && !out_ready;
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
		end
	end

	// Window counters and acked bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			next_q  <= '0;
			acked_q <= '0;
		end else begin
			if (cmd.send) begin
				acked_q[next_q] <= 1'b0;
				next_q          <= next_inc;
			end
			if (cmd.mark) begin
				acked_q[s] <= 1'b1;
			end
			if (cmd.step) begin
				acked_q[base_q] <= 1'b0;
				base_q          <= base_inc;
			end
		end
	end

	// Remember whether this ack stops a timer
	always_ff @(posedge clk) begin
		if (cmd.mark) begin
			stop_q <= !acked_q[s];
		end
	end

	// Payload store
	srsw_ram #(
		.WIDTH(PAYLOAD_BITS),
		.DEPTH(SEQ_RANGE)
	) u_store (
		.clk  (clk),
		.we   (cmd.send),
		.waddr(next_q),
		.wdata(pay_keep),
		.re   (cmd.rd),
		.raddr(s),
		.rdata(rd_data)
	);

	// Build the result for the code the controller picks
	always_comb begin
		res              = '0;
		res.status       = cmd.emit_code;
		res.window_base  = 3'(base_q);
		res.next_seq_out = 3'(next_q);
		case (cmd.emit_code)
			RS_SENT: begin
				res.tx_valid     = 1'b1;
				res.tx_seq       = 3'(next_q);
				res.tx_payload   = 64'(pay_keep);
				res.timer_start  = 1'b1;
				res.timer_seq    = 3'(next_q);
				res.next_seq_out = 3'(next_inc);
			end
			RS_ACK_TAKEN: begin
				res.timer_stop = stop_q;
				res.timer_seq  = stop_q ? 3'(s) : 3'd0;
			end
			RS_RESENT: begin
				res.tx_valid    = 1'b1;
				res.tx_seq      = 3'(s);
				res.tx_payload  = 64'(rd_data);
				res.timer_start = 1'b1;
				res.timer_seq   = 3'(s);
			end
			default: begin
			end
		endcase
	end

	// Output register: load on emit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

FILE: hdl/srsw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module srsw_ctrl
	import srsw_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EXEC   = 2'd1;
	localparam logic [1:0] S_SLIDE  = 2'd2;
	localparam logic [1:0] S_RESEND = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!stat.out_busy) begin
					state_d = S_IDLE;
					case (stat.op)
						OP_SEND: begin
							cmd.emit = 1'b1;
							if (stat.full) begin
								cmd.emit_code = RS_FULL;
							end else begin
								cmd.send      = 1'b1;
								cmd.emit_code = RS_SENT;
							end
						end
						OP_ACK: begin
							if (!stat.ck_ok) begin
								cmd.emit      = 1'b1;
								cmd.emit_code = RS_CORRUPT;
							end else if (!stat.in_flight) begin
								cmd.emit      = 1'b1;
								cmd.emit_code = RS_OUTSIDE;
							end else begin
								cmd.mark = 1'b1;
								state_d  = S_SLIDE;
							end
						end
						OP_TIMEOUT: begin
							if (stat.in_flight && !stat.acked_s) begin
								cmd.rd  = 1'b1;
								state_d = S_RESEND;
							end else begin
								cmd.emit      = 1'b1;
								cmd.emit_code = RS_IGNORED;
							end
						end
						default: begin
							cmd.emit      = 1'b1;
							cmd.emit_code = RS_IGNORED;
						end
					endcase
				end
			end
			S_SLIDE: begin
				// Advance base past acked entries, one per cycle
				if (stat.slide_more) begin
					cmd.step = 1'b1;
				end else if (!stat.out_busy) begin
					cmd.emit      = 1'b1;
					cmd.emit_code = RS_ACK_TAKEN;
					state_d       = S_IDLE;
				end
			end
			S_RESEND: begin
				if (!stat.out_busy) begin
					cmd.emit      = 1'b1;
					cmd.emit_code = RS_RESENT;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/selective_repeat_sender_window.sv
// Channel   Handshake               Payload
// input     in_valid / in_ready     in_item  (opcode, seq_in, checksum_ok, payload)
// result    out_valid / out_ready   out_item (status, tx, timer, window_base, next_seq_out)
// config    cfg_we                  cfg_wdata (window_size)
//
// One item at a time: an accept state then an execute state for send, corrupt or
// outside acks and ignored timeouts; a resend adds a state for the payload memory
// read; a taken ack adds a slide state that moves base one acked entry per cycle (at most 7).
// The result register frees the input side: a new item is taken while a result waits.
// Execution waits while the result register is full and not being taken.
// Reset clears base, next, acked bits and window_size (to 4); no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module selective_repeat_sender_window
	import srsw_pkg::*;
#(
	parameter int SEQ_BITS     = 3,
	parameter int PAYLOAD_BITS = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire in_item_t   in_item,
	output logic            out_valid,
	input  wire logic       out_ready,
	output res_item_t       out_item
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	srsw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	srsw_dp #(
		.SEQ_BITS    (SEQ_BITS),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_item  (in_item),
		.cmd      (cmd),
		.stat     (stat),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_item (out_item)
	);

	// Never send into a full window
	a_no_send_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.send |-> !stat.full)
		else $error("send issued with full window");

	// Never overwrite a result that is still waiting
	a_no_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !stat.out_busy)
		else $error("result emitted while output register busy");

	// One item at a time: no transfer right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in work");

endmodule

`default_nettype wire
